// File: design/tbbf_pkg.sv
// shared constants, types and hash step functions for the two-hash bloom filter
`default_nettype none

package tbbf_pkg;

   // running hash width and seeds
   localparam int HASH_W = 64;
   localparam logic [HASH_W-1:0] FNV_SEED = 64'hCBF2_9CE4_8422_2325;
   localparam logic [HASH_W-1:0] DJB_SEED = 64'd5381;

   // default filter size in bits
   localparam int DEFAULT_FILTER_BITS = 1024;

   // index reduction widths: 16-bit chunk fold, then barrett on the folded sum
   localparam int CHUNK_W = 16;
   localparam int FOLD_W = 34;
   localparam int BARRETT_K = 34;
   localparam int RECIP_W = 32;
   localparam int REM_W = 18;

   // operation codes
   typedef enum logic {
      OP_ADD = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // fnv-1a step: xor the byte, then times prime 2^40 + 0x1b3, mod 2^64
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // djb2 step: hash * 33 + byte, mod 2^64
   function automatic logic [HASH_W-1:0] djb_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      return (h << 5) + h + {56'd0, b};
   endfunction

endpackage

`default_nettype wire

// File: design/tbbf_reduce.sv
// pipelined reduction of a 64-bit hash modulo the filter size (four register stages)
`default_nettype none

module tbbf_reduce #(
   parameter int FILTER_BITS = tbbf_pkg::DEFAULT_FILTER_BITS,
   localparam int IDX_W = $clog2(FILTER_BITS)
) (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [tbbf_pkg::HASH_W-1:0] hash,
   output logic      [IDX_W-1:0]            index
);

   // 2^(16*i) mod n for the chunk fold
   localparam logic [tbbf_pkg::CHUNK_W-1:0] R1 =
      tbbf_pkg::CHUNK_W'((64'd1 << 16) % 64'(FILTER_BITS));
   localparam logic [tbbf_pkg::CHUNK_W-1:0] R2 =
      tbbf_pkg::CHUNK_W'((64'd1 << 32) % 64'(FILTER_BITS));
   localparam logic [tbbf_pkg::CHUNK_W-1:0] R3 =
      tbbf_pkg::CHUNK_W'((64'd1 << 48) % 64'(FILTER_BITS));
   // barrett reciprocal floor(2^k / n)
   localparam logic [63:0] RECIP64 = (64'd1 << tbbf_pkg::BARRETT_K) / 64'(FILTER_BITS);
   localparam logic [tbbf_pkg::RECIP_W-1:0] RECIP = RECIP64[tbbf_pkg::RECIP_W-1:0];
   localparam logic [tbbf_pkg::REM_W-1:0] MODULUS = tbbf_pkg::REM_W'(FILTER_BITS);

   localparam int PROD_W = tbbf_pkg::FOLD_W + tbbf_pkg::RECIP_W;

   logic [2*tbbf_pkg::CHUNK_W-1:0] prod1, prod2, prod3;
   logic [tbbf_pkg::FOLD_W-1:0]    fold_in, fold_ff;
   logic [PROD_W-1:0]              recip_prod;
   logic [tbbf_pkg::REM_W-1:0]     quot_in, quot_ff, low_ff;
   logic [2*tbbf_pkg::REM_W-1:0]   quot_mul;
   logic [tbbf_pkg::REM_W-1:0]     rem_in, rem_ff, rem_fix1, rem_fix2;
   logic [IDX_W-1:0]               index_ff;

   // fold the four 16-bit chunks into a congruent 34-bit sum
   always_comb begin
      prod1 = hash[31:16] * R1;
      prod2 = hash[47:32] * R2;
      prod3 = hash[63:48] * R3;
      fold_in = {18'd0, hash[15:0]} + {2'd0, prod1} + {2'd0, prod2} + {2'd0, prod3};
   end

   // quotient estimate, low bits only since the remainder stays below 2^18
   always_comb begin
      recip_prod = PROD_W'(fold_ff) * PROD_W'(RECIP);
      quot_in = recip_prod[tbbf_pkg::BARRETT_K +: tbbf_pkg::REM_W];
   end

   // remainder estimate, under three times the modulus
   always_comb begin
      quot_mul = quot_ff * MODULUS;
      rem_in = low_ff - quot_mul[tbbf_pkg::REM_W-1:0];
   end

   // two conditional subtracts finish the reduction
   always_comb begin
      rem_fix1 = (rem_ff >= MODULUS) ? rem_ff - MODULUS : rem_ff;
      rem_fix2 = (rem_fix1 >= MODULUS) ? rem_fix1 - MODULUS : rem_fix1;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (enable) begin
         fold_ff <= fold_in;
         quot_ff <= quot_in;
         low_ff <= fold_ff[tbbf_pkg::REM_W-1:0];
         rem_ff <= rem_in;
         index_ff <= rem_fix2[IDX_W-1:0];
      end
   end

   assign index = index_ff;

endmodule

`default_nettype wire

// File: design/two_hash_bloom_filter.sv
// two-hash bloom filter: byte-serial key hashing, index reduction and bit store
//
// req channel: one key byte per transaction with a last-byte flag and an
// operation (add or query); operation is looked at on the last byte only.
// rsp channel: one transaction per query key carrying likely_present; adds
// give no rsp transaction.
// Each byte updates the fnv-1a and djb2 running hashes in the cycle it is
// accepted. On the last byte both hashes go through a four-stage modulo
// reduction, then the bit store stage, then a registered read, and a query
// result goes from the read into the rsp result register.
// Throughput is one byte per cycle while the pipeline is not held; an add key
// holds the bit store stage for a second write, since the store has a single
// write port and takes its two bits in two writes.
// After reset the bit store is cleared one bit per cycle, index 0 up to
// FILTER_BITS-1, with req_ready low; the hashes start at their seeds.
// When the receiver stalls, the finished result stays in the rsp register and
// the whole pipeline holds, so req_ready drops until rsp is taken.
`default_nettype none

module two_hash_bloom_filter #(
   parameter int FILTER_BITS = tbbf_pkg::DEFAULT_FILTER_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_key_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_operation,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_likely_present
);

   localparam int IDX_W = $clog2(FILTER_BITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_BITS - 1);

   logic [tbbf_pkg::HASH_W-1:0] fnv_ff, djb_ff, fnv_in, djb_in;
   logic [tbbf_pkg::HASH_W-1:0] key_fnv_ff, key_djb_ff;
   logic [5:0]                  vld_ff;
   logic [4:0]                  qry_ff;
   logic                        sub_ff;
   logic                        clearing_ff;
   logic [IDX_W-1:0]            clr_cnt_ff;
   logic [IDX_W-1:0]            idx_a, idx_b;
   logic                        filter_ff [FILTER_BITS];
   logic                        rd_a_ff, rd_b_ff;
   logic                        rsp_valid_ff, rsp_present_ff;
   logic                        accept, key_done, out_stall, add_hold, adv;
   logic                        mem_we, mem_wdata;
   logic [IDX_W-1:0]            mem_waddr;

   // pipeline control: hold everything while rsp is stalled or an add is mid-write
   always_comb begin
      out_stall = rsp_valid_ff && !rsp_ready;
      add_hold = vld_ff[4] && !qry_ff[4] && !sub_ff;
      adv = !out_stall && !add_hold;
      req_ready = adv && !clearing_ff;
      accept = req_valid && req_ready;
      key_done = accept && req_last_byte;
   end

   // running hash next values
   always_comb begin
      fnv_in = tbbf_pkg::fnv_step(fnv_ff, req_key_byte);
      djb_in = tbbf_pkg::djb_step(djb_ff, req_key_byte);
   end

   // running hashes, reseeded after every key
   always_ff @(posedge clock) begin
      if (reset) begin
         fnv_ff <= tbbf_pkg::FNV_SEED;
         djb_ff <= tbbf_pkg::DJB_SEED;
      end else if (accept) begin
         if (req_last_byte) begin
            fnv_ff <= tbbf_pkg::FNV_SEED;
            djb_ff <= tbbf_pkg::DJB_SEED;
         end else begin
            fnv_ff <= fnv_in;
            djb_ff <= djb_in;
         end
      end
   end

   // finished key hashes
   always_ff @(posedge clock) begin
      if (adv) begin
         key_fnv_ff <= fnv_in;
         key_djb_ff <= djb_in;
         qry_ff <= {qry_ff[3:0], req_operation == tbbf_pkg::OP_QUERY};
      end
   end

   // stage valids; only queries move past the bit store stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4] && qry_ff[4], vld_ff[3:0], key_done};
      end
   end

   // hash to bit index reduction, one unit per hash
   tbbf_reduce #(
      .FILTER_BITS(FILTER_BITS)
   ) u_reduce_a (
      .clock(clock),
      .enable(adv),
      .hash(key_fnv_ff),
      .index(idx_a)
   );

   tbbf_reduce #(
      .FILTER_BITS(FILTER_BITS)
   ) u_reduce_b (
      .clock(clock),
      .enable(adv),
      .hash(key_djb_ff),
      .index(idx_b)
   );

   // second write of an add
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else if (adv) begin
         sub_ff <= 1'b0;
      end else if (add_hold) begin
         sub_ff <= 1'b1;
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_IDX) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // bit store write port
   always_comb begin
      mem_we = clearing_ff || (vld_ff[4] && !qry_ff[4]);
      mem_wdata = !clearing_ff;
      if (clearing_ff) begin
         mem_waddr = clr_cnt_ff;
      end else if (sub_ff) begin
         mem_waddr = idx_b;
      end else begin
         mem_waddr = idx_a;
      end
   end

   // bit store with two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         filter_ff[mem_waddr] <= mem_wdata;
      end
      if (adv) begin
         rd_a_ff <= filter_ff[idx_a];
         rd_b_ff <= filter_ff[idx_b];
      end
   end

   // result register, emptied by its own handshake even while an add holds the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[5];
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[5]) begin
         rsp_present_ff <= rd_a_ff && rd_b_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_likely_present = rsp_present_ff;

   // no key is in flight while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (vld_ff == '0))
      else $error("pipeline busy during clearing pass");

   // an add stays in the bit store stage for its second write
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !qry_ff[4] && !sub_ff) |=> (vld_ff[4] && sub_ff))
      else $error("add left the store stage before its second write");

   // a new result comes only from a query in the read stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[5]))
      else $error("result without a query");

   // reduced indices fall inside the filter
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> ((32'(idx_a) < FILTER_BITS) && (32'(idx_b) < FILTER_BITS)))
      else $error("bit index out of range");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for the two-hash bloom filter: directed key table, then random keys

module tb;

   localparam int BLOOM_SIZE = tbbf_pkg::DEFAULT_FILTER_BITS;
   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV_MULT = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] DJB_BASIS = 64'd5381;
   localparam int TOTAL_ITEMS = 1150;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 200;
   localparam int HOLD_AFTER = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int POOL_DEPTH = 64;
   localparam int DIR_ROWS = 25;

   typedef struct packed {
      logic [7:0] key_byte;
      logic last_byte;
      tbbf_pkg::op_type operation;
      logic typed;
      logic typed_present;
   } stim_row_type;

   typedef logic [7:0] key_type [$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_key_byte = 8'h00;
   logic req_last_byte = 1'b0;
   logic req_operation = tbbf_pkg::OP_ADD;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_likely_present;

   // shadow copy of the filter state
   logic shadow_bits [BLOOM_SIZE];
   logic [63:0] fnv_acc = FNV_BASIS;
   logic [63:0] djb_acc = DJB_BASIS;
   logic expected_presence [$];

   int items_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int rsp_wait = 0;
   logic long_hold = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   two_hash_bloom_filter #(
      .FILTER_BITS(BLOOM_SIZE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_key_byte(req_key_byte),
      .req_last_byte(req_last_byte),
      .req_operation(req_operation),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_likely_present(rsp_likely_present)
   );

   // running hash steps, wrapping at 64 bits
   function automatic logic [63:0] fnv_next(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_MULT;
   endfunction

   function automatic logic [63:0] djb_next(input logic [63:0] h, input logic [7:0] b);
      return h * 64'd33 + {56'd0, b};
   endfunction

   function automatic int unsigned bit_index(input logic [63:0] h);
      return 32'(h % 64'(BLOOM_SIZE));
   endfunction

   // advance the shadow filter by one accepted key byte
   function automatic void predict_byte(input logic [7:0] b, input logic last,
                                        input tbbf_pkg::op_type op,
                                        input logic typed, input logic typed_present);
      int unsigned ia;
      int unsigned ib;
      fnv_acc = fnv_next(fnv_acc, b);
      djb_acc = djb_next(djb_acc, b);
      if (last) begin
         ia = bit_index(fnv_acc);
         ib = bit_index(djb_acc);
         if (op == tbbf_pkg::OP_QUERY) begin
            expected_presence.insert(expected_presence.size(),
                                     typed ? typed_present
                                           : (shadow_bits[ia] && shadow_bits[ib]));
         end else begin
            shadow_bits[ia] = 1'b1;
            shadow_bits[ib] = 1'b1;
         end
         fnv_acc = FNV_BASIS;
         djb_acc = DJB_BASIS;
      end
   endfunction

   function automatic void note_mismatch(input string what, input logic want, input logic got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at cycle %0d: %s expected %0b got %0b",
                  mismatches, cycle_count, what, want, got);
   endfunction

   function automatic key_type random_key(input int len);
      key_type k;
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 7);
         k.insert(k.size(),
                  pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
      return k;
   endfunction

   // offer one byte after a random gap (none while items_sent bit 6 is set), hold until the transaction is taken
   task automatic send_byte(input logic [7:0] b, input logic last, input tbbf_pkg::op_type op,
                            input logic typed, input logic typed_present);
      int gap;
      gap = items_sent[6] ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_key_byte = b;
      req_last_byte = last;
      req_operation = op;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, last, op, typed, typed_present);
      items_sent++;
      @(negedge clock);
   endtask

   // inner bytes carry a random operation, which the block must ignore
   task automatic send_key(input key_type key, input tbbf_pkg::op_type op);
      tbbf_pkg::op_type byte_op;
      for (int i = 0; i < key.size(); i++) begin
         byte_op = (i == key.size() - 1) ? op : tbbf_pkg::op_type'($urandom_range(0, 1));
         send_byte(key[i], i == key.size() - 1, byte_op, 1'b0, 1'b0);
      end
   endtask

   // response side: random stall after each transaction while results_seen bit 3 is clear, plus one long hold
   always @(negedge clock) begin
      rsp_ready = !reset && !long_hold && rsp_wait == 0;
      if (rsp_wait > 0)
         rsp_wait--;
   end

   initial begin
      while (items_sent < HOLD_AFTER) @(posedge clock);
      long_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold = 1'b0;
   end

   // response checking and run watchdog
   always @(posedge clock) begin
      logic want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         if (expected_presence.size() == 0) begin
            note_mismatch("response with nothing pending", 1'bx, rsp_likely_present);
         end else begin
            want = expected_presence.pop_front();
            if (want !== rsp_likely_present)
               note_mismatch("likely_present", want, rsp_likely_present);
         end
         results_seen++;
         rsp_wait = results_seen[3] ? 0 : $urandom_range(0, 7);
      end
   end

   initial begin
      stim_row_type rows [DIR_ROWS];
      key_type key_pool [POOL_DEPTH];
      int pool_count;
      key_type key;
      logic [7:0] eq_key [3];
      logic found;
      logic [63:0] fa;
      logic [63:0] da;
      int pick;
      int len;

      foreach (shadow_bits[i])
         shadow_bits[i] = 1'b0;
      pool_count = 0;

      // find a three-byte key whose two indices land on the same bit
      found = 1'b0;
      eq_key = '{8'h00, 8'h00, 8'h00};
      for (int v = 0; v < (1 << 24) && !found; v++) begin
         fa = FNV_BASIS;
         da = DJB_BASIS;
         for (int j = 0; j < 3; j++) begin
            fa = fnv_next(fa, 8'(v >> (8 * j)));
            da = djb_next(da, 8'(v >> (8 * j)));
         end
         if (bit_index(fa) == bit_index(da)) begin
            found = 1'b1;
            for (int j = 0; j < 3; j++)
               eq_key[j] = 8'(v >> (8 * j));
         end
      end

      // directed keys: empty filter, single-byte extremes, ignored inner operation,
      // same-bit key, long key
      rows = '{
         '{8'h00, 1'b1, tbbf_pkg::OP_QUERY, 1'b1, 1'b0},
         '{8'hFF, 1'b1, tbbf_pkg::OP_QUERY, 1'b1, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_QUERY, 1'b1, 1'b1},
         '{8'hFF, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_QUERY, 1'b1, 1'b1},
         '{8'h00, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'h00, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'h00, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'h00, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'h00, 1'b1, tbbf_pkg::OP_QUERY, 1'b1, 1'b1},
         '{8'hFF, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_ADD,   1'b0, 1'b0},
         '{8'hFF, 1'b0, tbbf_pkg::OP_QUERY, 1'b0, 1'b0},
         '{8'hFF, 1'b1, tbbf_pkg::OP_QUERY, 1'b0, 1'b0}
      };
      for (int i = 8; i < 17; i++)
         rows[i].key_byte = eq_key[(i - 8) % 3];

      // reset, then wait out the clearing pass through the handshake
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_byte(rows[i].key_byte, rows[i].last_byte, rows[i].operation,
                   rows[i].typed, rows[i].typed_present);

      // random keys: adds into a pool, queries of pooled and fresh keys, long keys
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         len = (pick >= 90) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         if (pick < 35 || pool_count == 0) begin
            key = random_key(len);
            send_key(key, tbbf_pkg::OP_ADD);
            if (pool_count < POOL_DEPTH)
               key_pool[pool_count++] = key;
            else
               key_pool[$urandom_range(0, POOL_DEPTH - 1)] = key;
         end else if (pick < 65) begin
            send_key(key_pool[$urandom_range(0, pool_count - 1)], tbbf_pkg::OP_QUERY);
         end else begin
            send_key(random_key(len), (pick < 90) ? tbbf_pkg::OP_QUERY
                                                  : tbbf_pkg::op_type'($urandom_range(0, 1)));
         end
      end
      req_valid = 1'b0;

      // drain outstanding responses
      while (expected_presence.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_presence.size() != 0) begin
         mismatches += expected_presence.size();
         $display("%0d responses never arrived", expected_presence.size());
      end

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
design/tbbf_pkg.sv
design/tbbf_reduce.sv
design/two_hash_bloom_filter.sv
tb/tb.sv
